// File: hdl/assert_macros.svh
// Assertion macros shared by the console engine RTL.
// Include with the bare file name; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked on every rising edge out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen on a rising edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: hdl/tcc_pkg.sv
// Shared types, geometry constants and helper functions of the text console engine.
// No dependencies.
`default_nettype none

package tcc_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int NCELLS   = COLS * ROWS;

    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CELL_W = 16;

    // Port field widths
    localparam int F_COL_W  = 7;
    localparam int F_ROW_W  = 5;
    localparam int F_POS_W  = 11;
    localparam int F_ADDR_W = 11;
    localparam int ATTR_W   = 7;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 7'h07;

    typedef enum logic [1:0] {
        CMD_PUT_CHAR = 2'd0,
        CMD_SET_CUR  = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_TEXT_ATTR  = 1'b0,
        CFG_CURSOR_EN  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_TAB,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic              cur_en;
        logic              sync;
    } t_cfg;

    typedef struct packed {
        t_cmd                cmd;
        logic [7:0]          char_code;
        logic [7:0]          want_col;
        logic [7:0]          want_row;
        logic [F_ADDR_W-1:0] cell_addr;
    } t_req;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] hw_pos;
        logic [CELL_W-1:0] read_cell;
        logic              scrolled;
    } t_result;

    // Columns that are tab stops
    function automatic logic [COLS-1:0] f_tab_mask();
        logic [COLS-1:0] v;
        v = '0;
        for (int k = 0; k < COLS; k += TAB_STOP) begin
            v[k] = 1'b1;
        end
        return v;
    endfunction

    localparam logic [COLS-1:0] TAB_MASK = f_tab_mask();

    function automatic logic [ADDR_W-1:0] f_cell_addr(logic [ROW_W-1:0] row,
                                                      logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// File: hdl/tcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/tcc_seq.sv
// Command sequencer of the console engine: cursor state, cell store walks and reads.
// Depends on tcc_pkg, tcc_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcc_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tcc_pkg::t_cfg    i_cfg,
    input  wire logic             i_req_valid,
    input  wire tcc_pkg::t_req    i_req,
    output      logic             o_req_ready,
    output      logic             o_res_valid,
    input  wire logic             i_res_ready,
    output      tcc_pkg::t_result o_res
);

    tcc_pkg::t_state r_state, n_state;
    tcc_pkg::t_req   r_req;

    logic [tcc_pkg::COL_W-1:0]  r_col, n_col;
    logic [tcc_pkg::ROW_W-1:0]  r_row, n_row;
    logic [tcc_pkg::ADDR_W-1:0] r_hw, n_hw;
    logic [tcc_pkg::ADDR_W-1:0] r_cnt, n_cnt;
    logic                       r_sc, n_sc;
    logic [tcc_pkg::CELL_W-1:0] r_cell, n_cell;

    logic                       w_we;
    logic [tcc_pkg::ADDR_W-1:0] w_waddr, w_raddr;
    logic [tcc_pkg::CELL_W-1:0] w_wdata, w_rdata;

    logic [tcc_pkg::CELL_W-1:0] w_blank;
    logic [tcc_pkg::ADDR_W-1:0] w_cur_addr, w_bs_addr, w_hw_res;
    logic [tcc_pkg::COL_W-1:0]  w_bs_col, w_col_inc;
    logic [tcc_pkg::ROW_W-1:0]  w_bs_row;
    logic                       w_last_col, w_last_row, w_cnt_last;
    logic                       w_is_lf, w_is_cr, w_is_bs, w_is_tab, w_is_print;
    logic                       w_addr_ok, w_accept, w_sync_pos;

    tcc_ram #(
        .WIDTH (tcc_pkg::CELL_W),
        .DEPTH (tcc_pkg::NCELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_blank    = {1'b0, i_cfg.attr, tcc_pkg::CH_SPACE};
    assign w_cur_addr = tcc_pkg::f_cell_addr(r_row, r_col);
    assign w_last_col = (r_col == tcc_pkg::COL_W'(tcc_pkg::COLS - 1));
    assign w_last_row = (r_row == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1));
    assign w_cnt_last = (r_cnt == tcc_pkg::ADDR_W'(tcc_pkg::NCELLS - 1));
    assign w_col_inc  = r_col + 1'b1;

    assign w_is_lf    = (r_req.char_code == tcc_pkg::CH_LF);
    assign w_is_cr    = (r_req.char_code == tcc_pkg::CH_CR);
    assign w_is_bs    = (r_req.char_code == tcc_pkg::CH_BS);
    assign w_is_tab   = (r_req.char_code == tcc_pkg::CH_TAB);
    assign w_is_print = (r_req.char_code >= tcc_pkg::CH_SPACE) &&
                        (r_req.char_code != tcc_pkg::CH_DEL);
    assign w_addr_ok  = (32'(r_req.cell_addr) < 32'(tcc_pkg::NCELLS));

    // Backspace target: step left, wrap to the end of the previous row, stick at home
    always_comb begin
        w_bs_col = r_col;
        w_bs_row = r_row;
        if (r_col != '0) begin
            w_bs_col = r_col - 1'b1;
        end else if (r_row != '0) begin
            w_bs_col = tcc_pkg::COL_W'(tcc_pkg::COLS - 1);
            w_bs_row = r_row - 1'b1;
        end
    end
    assign w_bs_addr = tcc_pkg::f_cell_addr(w_bs_row, w_bs_col);

    assign w_accept   = i_req_valid && (r_state == tcc_pkg::ST_IDLE);
    assign w_sync_pos = (r_req.cmd != tcc_pkg::CMD_READ) && i_cfg.cur_en;
    assign w_hw_res   = w_sync_pos ? w_cur_addr : r_hw;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcc_pkg::ST_INIT: begin
                if (w_cnt_last) n_state = tcc_pkg::ST_IDLE;
            end
            tcc_pkg::ST_IDLE: begin
                if (w_accept) n_state = tcc_pkg::ST_EXEC;
            end
            tcc_pkg::ST_EXEC: begin
                unique case (r_req.cmd)
                    tcc_pkg::CMD_PUT_CHAR: begin
                        if (w_is_tab) begin
                            n_state = tcc_pkg::ST_TAB;
                        end else if ((w_is_lf || (w_is_print && w_last_col)) && w_last_row) begin
                            n_state = tcc_pkg::ST_SCROLL;
                        end else begin
                            n_state = tcc_pkg::ST_FINISH;
                        end
                    end
                    tcc_pkg::CMD_SET_CUR: n_state = tcc_pkg::ST_FINISH;
                    tcc_pkg::CMD_CLEAR:   n_state = tcc_pkg::ST_CLEAR;
                    tcc_pkg::CMD_READ: begin
                        n_state = w_addr_ok ? tcc_pkg::ST_READ : tcc_pkg::ST_FINISH;
                    end
                    default: n_state = tcc_pkg::ST_FINISH;
                endcase
            end
            tcc_pkg::ST_TAB: begin
                if (w_last_col) begin
                    n_state = w_last_row ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_FINISH;
                end else if (tcc_pkg::TAB_MASK[w_col_inc]) begin
                    n_state = tcc_pkg::ST_FINISH;
                end
            end
            tcc_pkg::ST_SCROLL: begin
                if (r_cnt == tcc_pkg::ADDR_W'(tcc_pkg::NCELLS - tcc_pkg::COLS)) begin
                    n_state = tcc_pkg::ST_BLANK;
                end
            end
            tcc_pkg::ST_BLANK,
            tcc_pkg::ST_CLEAR: begin
                if (w_cnt_last) n_state = tcc_pkg::ST_FINISH;
            end
            tcc_pkg::ST_READ:   n_state = tcc_pkg::ST_FINISH;
            tcc_pkg::ST_FINISH: begin
                if (i_res_ready) n_state = tcc_pkg::ST_IDLE;
            end
            default: n_state = tcc_pkg::ST_INIT;
        endcase
    end

    // Datapath and store access
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_hw    = r_hw;
        n_cnt   = r_cnt;
        n_sc    = r_sc;
        n_cell  = r_cell;
        w_we    = 1'b0;
        w_waddr = w_cur_addr;
        w_wdata = w_blank;
        w_raddr = tcc_pkg::ADDR_W'(r_req.cell_addr);
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            tcc_pkg::ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = tcc_pkg::RESET_CELL;
                n_cnt   = w_cnt_last ? '0 : r_cnt + 1'b1;
            end
            tcc_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_cfg.sync) n_hw = w_cur_addr;
                if (w_accept) begin
                    n_sc   = 1'b0;
                    n_cell = '0;
                    n_cnt  = '0;
                end
            end
            tcc_pkg::ST_EXEC: begin
                unique case (r_req.cmd)
                    tcc_pkg::CMD_PUT_CHAR: begin
                        if (w_is_lf || (w_is_print && w_last_col)) begin
                            n_col = '0;
                            if (w_last_row) n_sc = 1'b1;
                            else            n_row = r_row + 1'b1;
                        end else if (w_is_print) begin
                            n_col = w_col_inc;
                        end else if (w_is_cr) begin
                            n_col = '0;
                        end else if (w_is_bs) begin
                            n_col   = w_bs_col;
                            n_row   = w_bs_row;
                            w_we    = 1'b1;
                            w_waddr = w_bs_addr;
                        end
                        if (w_is_print) begin
                            w_we    = 1'b1;
                            w_wdata = {1'b0, i_cfg.attr, r_req.char_code};
                        end
                    end
                    tcc_pkg::CMD_SET_CUR: begin
                        n_col = (r_req.want_col >= 8'(tcc_pkg::COLS)) ?
                                tcc_pkg::COL_W'(tcc_pkg::COLS - 1) :
                                tcc_pkg::COL_W'(r_req.want_col);
                        n_row = (r_req.want_row >= 8'(tcc_pkg::ROWS)) ?
                                tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1) :
                                tcc_pkg::ROW_W'(r_req.want_row);
                    end
                    tcc_pkg::CMD_CLEAR: begin
                        n_col = '0;
                        n_row = '0;
                    end
                    tcc_pkg::CMD_READ: ;
                    default: ;
                endcase
            end
            tcc_pkg::ST_TAB: begin
                w_we = 1'b1;
                if (w_last_col) begin
                    n_col = '0;
                    if (w_last_row) n_sc = 1'b1;
                    else            n_row = r_row + 1'b1;
                end else begin
                    n_col = w_col_inc;
                end
            end
            tcc_pkg::ST_SCROLL: begin
                // Read one row ahead, write back the cell fetched last cycle
                w_raddr = r_cnt + tcc_pkg::ADDR_W'(tcc_pkg::COLS);
                w_we    = (r_cnt != '0);
                w_waddr = r_cnt - 1'b1;
                w_wdata = w_rdata;
                if (r_cnt != tcc_pkg::ADDR_W'(tcc_pkg::NCELLS - tcc_pkg::COLS)) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcc_pkg::ST_BLANK,
            tcc_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                n_cnt   = r_cnt + 1'b1;
            end
            tcc_pkg::ST_READ: begin
                n_cell = w_rdata;
            end
            tcc_pkg::ST_FINISH: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_hw = w_hw_res;
            end
            default: ;
        endcase
    end

    assign o_res = '{col:       r_col,
                     row:       r_row,
                     hw_pos:    w_hw_res,
                     read_cell: r_cell,
                     scrolled:  r_sc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcc_pkg::ST_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_hw    <= '0;
            r_cnt   <= '0;
            r_sc    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_hw    <= n_hw;
            r_cnt   <= n_cnt;
            r_sc    <= n_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    `ASSERT_CLK(a_cursor_range, i_clk, i_rst_n,
        (32'(r_col) < tcc_pkg::COLS) && (32'(r_row) < tcc_pkg::ROWS),
        "text cursor left the screen")
    `ASSERT_CLK(a_hw_range, i_clk, i_rst_n,
        32'(r_hw) < tcc_pkg::NCELLS, "hardware cursor out of range")
    `ASSERT_CLK(a_scroll_flag, i_clk, i_rst_n,
        (r_state == tcc_pkg::ST_SCROLL) |-> (r_sc && (r_col == '0)),
        "scroll running without flag or with cursor off column zero")
    `ASSERT_NEVER(a_scroll_cnt, i_clk, i_rst_n,
        (r_state == tcc_pkg::ST_SCROLL) &&
        (32'(r_cnt) > tcc_pkg::NCELLS - tcc_pkg::COLS),
        "scroll counter ran past the last source row")

endmodule

`default_nettype wire

// File: hdl/text_console_cell_engine_core.sv
// Top level of the text console engine: stream ports, config registers, result register.
// Depends on tcc_pkg and tcc_seq.
//
// Usage:
//   Requests enter on s_axis_*: the command code in tuser, its operands in tdata.
//   Each request yields exactly one result on m_axis_* (cursor, hardware cursor
//   position, read cell and a scroll flag), in request order.
//   Configuration writes (text attribute, cursor enable) use i_cfg_valid with
//   i_cfg_index and i_cfg_data; o_cfg_ready is always high. Write them only while
//   no request is in flight.
//   Scroll (newline or wrap on the last row) and clear screen walk the whole store
//   through the single store port pair; a tab blanks cells up to the next tab stop,
//   and a read cell waits for the registered read data of the store.
//   One request is worked on at a time; the next is taken once the result is in
//   the output register, even while the receiver still holds off m_axis_tready.
//   After reset the store is filled with grey blanks in a pass over every cell during
//   which s_axis_tready stays low. A stalled result holds until taken.
`default_nettype none

module text_console_cell_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // char_code[7:0], want_col[15:8],
                                            // want_row[23:16], cell_addr[34:24], zero
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // result stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata   // cursor_col[6:0], cursor_row[11:7],
                                            // hw_cursor_pos[22:12], read_cell[38:23],
                                            // scrolled[39]
);

    logic [tcc_pkg::ATTR_W-1:0]     r_attr;
    logic                           r_cur_en;
    logic                           r_out_valid;
    logic [tcc_pkg::OUT_DATA_W-1:0] r_out_data;

    tcc_pkg::t_cfg    w_cfg;
    tcc_pkg::t_req    w_req;
    tcc_pkg::t_result w_res;
    logic             w_res_valid, w_res_ready, w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr   <= tcc_pkg::RESET_ATTR;
            r_cur_en <= 1'b1;
        end else if (w_cfg_wr) begin
            unique case (tcc_pkg::t_cfg_idx'(i_cfg_index))
                tcc_pkg::CFG_TEXT_ATTR: r_attr   <= i_cfg_data;
                tcc_pkg::CFG_CURSOR_EN: r_cur_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Enabling the cursor pulls the hardware position to the text cursor at once
    assign w_cfg = '{attr:   r_attr,
                     cur_en: r_cur_en,
                     sync:   w_cfg_wr &&
                             (tcc_pkg::t_cfg_idx'(i_cfg_index) == tcc_pkg::CFG_CURSOR_EN) &&
                             i_cfg_data[0]};

    assign w_req = '{cmd:       tcc_pkg::t_cmd'(s_axis_tuser),
                     char_code: s_axis_tdata[7:0],
                     want_col:  s_axis_tdata[15:8],
                     want_row:  s_axis_tdata[23:16],
                     cell_addr: s_axis_tdata[34:24]};

    tcc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req_valid (s_axis_tvalid),
        .i_req       (w_req),
        .o_req_ready (s_axis_tready),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Output register: free when empty or drained this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= {w_res.scrolled,
                           w_res.read_cell,
                           tcc_pkg::F_POS_W'(w_res.hw_pos),
                           tcc_pkg::F_ROW_W'(w_res.row),
                           tcc_pkg::F_COL_W'(w_res.col)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: tb/sv/tcc_console_monitor.sv
// Watches the configuration, request and result channels of the text console engine,
// predicts each result from its own screen image and compares. Depends on tcc_pkg.
module tcc_console_monitor
    import tcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,
    input  logic [1:0]  i_req_user,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] hw_pos;
        logic [15:0] read_cell;
        logic        scrolled;
    } t_outcome;

    logic [15:0]       cell_image [NCELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    int unsigned       hw_pos;
    logic [ATTR_W-1:0] attr_reg;
    logic              cur_en;
    t_outcome          awaited_results [$];
    int                result_idx = 0;
    int                fail_total = 0;
    int                pending_total = 0;

    assign o_pending    = pending_total;
    assign o_fail_count = fail_total;

    function automatic logic [15:0] blank_cell();
        return {1'b0, attr_reg, CH_SPACE};
    endfunction

    function automatic void write_cell(logic [7:0] ch);
        int unsigned idx;
        idx = cur_row * COLS + cur_col;
        if (idx < NCELLS) cell_image[idx] = {1'b0, attr_reg, ch};
    endfunction

    function automatic void follow_cursor();
        if (cur_en) hw_pos = cur_row * COLS + cur_col;
    endfunction

    // Return 1 when the move past the last row scrolls the image up.
    function automatic bit next_line();
        cur_col = 0;
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            return 1'b0;
        end
        for (int k = 0; k < NCELLS - COLS; k++) cell_image[k] = cell_image[k + COLS];
        for (int k = NCELLS - COLS; k < NCELLS; k++) cell_image[k] = blank_cell();
        return 1'b1;
    endfunction

    function automatic bit apply_char(logic [7:0] ch);
        bit scrolled;
        scrolled = 1'b0;
        case (ch)
            CH_LF: scrolled = next_line();
            CH_CR: cur_col = 0;
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_row--;
                    cur_col = COLS - 1;
                end
                write_cell(CH_SPACE);
            end
            CH_TAB: begin
                do begin
                    write_cell(CH_SPACE);
                    cur_col++;
                    if (cur_col >= COLS) begin
                        if (next_line()) scrolled = 1'b1;
                    end
                end while (cur_col % TAB_STOP != 0);
            end
            default: begin
                // other control codes and delete leave everything alone
                if (ch >= CH_SPACE && ch != CH_DEL) begin
                    write_cell(ch);
                    cur_col++;
                    if (cur_col >= COLS) scrolled = next_line();
                end
            end
        endcase
        return scrolled;
    endfunction

    function automatic t_outcome run_command(t_req r);
        t_outcome o;
        o = '0;
        case (r.cmd)
            CMD_PUT_CHAR: begin
                o.scrolled = apply_char(r.char_code);
                follow_cursor();
            end
            CMD_SET_CUR: begin
                cur_col = (r.want_col >= COLS) ? COLS - 1 : r.want_col;
                cur_row = (r.want_row >= ROWS) ? ROWS - 1 : r.want_row;
                follow_cursor();
            end
            CMD_CLEAR: begin
                for (int k = 0; k < NCELLS; k++) cell_image[k] = blank_cell();
                cur_col = 0;
                cur_row = 0;
                follow_cursor();
            end
            CMD_READ: begin
                if (r.cell_addr < NCELLS) o.read_cell = cell_image[r.cell_addr];
            end
        endcase
        o.col    = 7'(cur_col);
        o.row    = 5'(cur_row);
        o.hw_pos = 11'(hw_pos);
        return o;
    endfunction

    function automatic void apply_setting(logic idx, logic [6:0] value);
        case (t_cfg_idx'(idx))
            CFG_TEXT_ATTR: attr_reg = value;
            CFG_CURSOR_EN: begin
                cur_en = value[0];
                follow_cursor();
            end
        endcase
    endfunction

    function automatic void clear_image();
        for (int k = 0; k < NCELLS; k++) cell_image[k] = RESET_CELL;
        cur_col  = 0;
        cur_row  = 0;
        hw_pos   = 0;
        attr_reg = RESET_ATTR;
        cur_en   = 1'b1;
        awaited_results.delete();
    endfunction

    function automatic void check_result(logic [39:0] bus);
        t_outcome got;
        t_outcome want;
        got.col       = bus[6:0];
        got.row       = bus[11:7];
        got.hw_pos    = bus[22:12];
        got.read_cell = bus[38:23];
        got.scrolled  = bus[39];
        result_idx++;
        if (awaited_results.size() == 0) begin
            fail_total++;
            if (fail_total <= 10)
                $display("result %0d arrived with no request outstanding", result_idx);
            return;
        end
        want = awaited_results.pop_front();
        if (got.col !== want.col || got.row !== want.row || got.hw_pos !== want.hw_pos ||
            got.read_cell !== want.read_cell || got.scrolled !== want.scrolled) begin
            fail_total++;
            if (fail_total <= 10)
                $display("result %0d exp %0d,%0d hw %0d cell %h sc %0d | got %0d,%0d hw %0d cell %h sc %0d",
                         result_idx, want.col, want.row, want.hw_pos, want.read_cell,
                         want.scrolled, got.col, got.row, got.hw_pos, got.read_cell,
                         got.scrolled);
        end
    endfunction

    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            clear_image();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_setting(i_cfg_index, i_cfg_data);
            if (i_res_valid && i_res_ready) check_result(i_res_data);
            if (i_req_valid && i_req_ready) begin
                r.cmd       = t_cmd'(i_req_user);
                r.char_code = i_req_data[7:0];
                r.want_col  = i_req_data[15:8];
                r.want_row  = i_req_data[23:16];
                r.cell_addr = i_req_data[34:24];
                awaited_results.push_back(run_command(r));
            end
        end
        pending_total = awaited_results.size();
    end

endmodule

// File: tb/sv/tb.sv
// Top of the text console engine testbench: clock, reset, request and setting stimulus,
// result backpressure and the verdict. Depends on tcc_pkg, tcc_console_monitor and the RTL.
module tb;
    import tcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 300;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int LONG_GAP     = 40;
    // every request a full store pass plus both sides' longest gaps, three times over
    localparam int RUN_LIMIT    = 3 * ((RANDOM_ITEMS + 40) * (NCELLS + 2 * LONG_GAP + 16)
                                       + 2 * NCELLS);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int tx_quiet = 0;
    int rx_quiet = 0;

    text_console_cell_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tcc_console_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, and runs with none at all.
    function automatic int idle_cycles(inout int quiet_left);
        int pick;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, LONG_GAP);
    endfunction

    // Every field random, so the ones a command ignores still toggle.
    function automatic t_req background_request();
        t_req r;
        r.cmd       = t_cmd'($urandom_range(0, 3));
        r.char_code = 8'($urandom);
        r.want_col  = 8'($urandom);
        r.want_row  = 8'($urandom);
        r.cell_addr = 11'($urandom);
        return r;
    endfunction

    function automatic t_req shaped_request(t_cmd c, int unsigned v0, int unsigned v1);
        t_req r;
        r = background_request();
        r.cmd = c;
        case (c)
            CMD_PUT_CHAR: r.char_code = 8'(v0);
            CMD_SET_CUR: begin
                r.want_col = 8'(v0);
                r.want_row = 8'(v1);
            end
            CMD_READ: r.cell_addr = 11'(v0);
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int pick;
        int sub;
        r = background_request();
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 9);
        if (pick < 71) begin
            r.cmd = CMD_PUT_CHAR;
            if (pick < 45) r.char_code = 8'($urandom_range(CH_SPACE, 8'hFF));
            else if (pick < 53) r.char_code = CH_LF;
            else if (pick < 57) r.char_code = CH_CR;
            else if (pick < 62) r.char_code = CH_BS;
            else if (pick < 68) r.char_code = CH_TAB;
            else if (sub == 0) r.char_code = CH_DEL;
            else r.char_code = 8'($urandom_range(0, CH_SPACE - 1));
        end else if (pick < 81) begin
            r.cmd = CMD_SET_CUR;
            if (sub < 4) r.want_col = 8'($urandom_range(0, COLS - 1));
            else if (sub < 7) r.want_col = 8'($urandom_range(COLS - 10, COLS - 1));
            sub = $urandom_range(0, 9);
            if (sub < 4) r.want_row = 8'($urandom_range(0, ROWS - 1));
            else if (sub < 7) r.want_row = 8'($urandom_range(ROWS - 5, ROWS - 1));
        end else if (pick < 83) begin
            r.cmd = CMD_CLEAR;
        end else begin
            r.cmd = CMD_READ;
            if (sub < 4) r.cell_addr = 11'($urandom_range(NCELLS - 2 * COLS, NCELLS - 1));
            else if (sub < 7) r.cell_addr = 11'($urandom_range(0, 2 * COLS - 1));
            else if (sub < 9) r.cell_addr = 11'($urandom_range(0, NCELLS - 1));
            else r.cell_addr = 11'($urandom_range(NCELLS, 2047));
        end
        return r;
    endfunction

    task automatic push_request(input t_req r);
        int gap;
        gap = idle_cycles(tx_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r.cell_addr, r.want_row, r.want_col, r.char_code};
        s_axis_tuser  <= r.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_setting(input t_cfg_idx idx, input logic [6:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [6:0] attr, input bit cur_en, input int count);
        wait_drained();
        write_setting(CFG_TEXT_ATTR, attr);
        // upper data bits are don't-care for the enable register
        write_setting(CFG_CURSOR_EN, {6'($urandom), cur_en});
        repeat (count) push_request(random_request());
    endtask

    // Result backpressure: stall after some results and at random idle points.
    initial begin : result_sink
        int hold;
        bit took;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            took = m_axis_tvalid && m_axis_tready;
            @(negedge i_clk);
            if (hold == 0 && (took || $urandom_range(0, 7) == 0)) hold = idle_cycles(rx_quiet);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUT_CHAR;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_setting(CFG_TEXT_ATTR, 7'h7F);
        write_setting(CFG_CURSOR_EN, 7'h01);
        // reset contents, last cell and addresses past the store
        push_request(shaped_request(CMD_READ, 0, 0));
        push_request(shaped_request(CMD_READ, NCELLS - 1, 0));
        push_request(shaped_request(CMD_READ, NCELLS, 0));
        push_request(shaped_request(CMD_READ, 2047, 0));
        // printable codes, then codes that must be dropped, then the lowest printable one
        push_request(shaped_request(CMD_PUT_CHAR, 8'h41, 0));
        push_request(shaped_request(CMD_PUT_CHAR, 8'hFF, 0));
        push_request(shaped_request(CMD_PUT_CHAR, CH_DEL, 0));
        push_request(shaped_request(CMD_PUT_CHAR, 8'h00, 0));
        push_request(shaped_request(CMD_PUT_CHAR, 8'h1F, 0));
        push_request(shaped_request(CMD_PUT_CHAR, CH_SPACE, 0));
        push_request(shaped_request(CMD_READ, 0, 0));
        // clamp to the bottom-right corner, then wrap into a scroll
        push_request(shaped_request(CMD_SET_CUR, 255, 255));
        push_request(shaped_request(CMD_PUT_CHAR, 8'h7E, 0));
        // tab on the right edge wraps to the next row
        push_request(shaped_request(CMD_SET_CUR, COLS - 1, 3));
        push_request(shaped_request(CMD_PUT_CHAR, CH_TAB, 0));
        // backspace at the top-left corner and at the start of a row
        push_request(shaped_request(CMD_SET_CUR, 0, 0));
        push_request(shaped_request(CMD_PUT_CHAR, CH_BS, 0));
        push_request(shaped_request(CMD_SET_CUR, 0, 5));
        push_request(shaped_request(CMD_PUT_CHAR, CH_BS, 0));
        push_request(shaped_request(CMD_PUT_CHAR, CH_CR, 0));
        push_request(shaped_request(CMD_PUT_CHAR, CH_LF, 0));
        push_request(shaped_request(CMD_SET_CUR, 3, ROWS - 1));
        push_request(shaped_request(CMD_PUT_CHAR, CH_TAB, 0));
        push_request(shaped_request(CMD_PUT_CHAR, CH_LF, 0));
        push_request(shaped_request(CMD_READ, NCELLS - COLS, 0));
        push_request(shaped_request(CMD_CLEAR, 0, 0));

        run_phase(7'h00, 1'b0, PHASE_ITEMS);
        run_phase(7'($urandom), 1'b1, PHASE_ITEMS);
        run_phase(7'($urandom), 1'b0, PHASE_ITEMS);
        run_phase(7'($urandom), 1'b1, RANDOM_ITEMS - 3 * PHASE_ITEMS);
        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
